@@ rtl/aes_pkg.sv @@
`default_nettype none

package aes_pkg;

    localparam int MAX_ROUND_KEYS = 15;

    localparam logic [2:0] REG_KEY_0 = 3'd0;
    localparam logic [2:0] REG_KEY_1 = 3'd1;
    localparam logic [2:0] REG_KEY_2 = 3'd2;
    localparam logic [2:0] REG_KEY_3 = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;

    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;
    localparam logic [1:0] KEY_SIZE_256 = 2'd2;

    localparam logic ACTION_ENCRYPT = 1'b0;
    localparam logic ACTION_DECRYPT = 1'b1;

    typedef logic [255:0][7:0] t_byte_tab;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] y;
        acc = 8'h00;
        y = b;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) begin
                acc = acc ^ y;
            end
            y = {y[6:0], 1'b0} ^ (y[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] sq;
        logic [7:0] acc;
        sq = gf_mul(a, a);
        acc = sq;
        for (int i = 1; i < 7; i++) begin
            sq = gf_mul(sq, sq);
            acc = gf_mul(acc, sq);
        end
        return acc;
    endfunction

    function automatic t_byte_tab gen_sbox();
        t_byte_tab t;
        logic [7:0] b;
        for (int a = 0; a < 256; a++) begin
            b = gf_inv(8'(a));
            t[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
        return t;
    endfunction

    function automatic t_byte_tab gen_inv_sbox();
        t_byte_tab s;
        t_byte_tab t;
        s = gen_sbox();
        t = '0;
        for (int a = 0; a < 256; a++) begin
            t[s[a]] = 8'(a);
        end
        return t;
    endfunction

    localparam t_byte_tab SBOX = gen_sbox();
    localparam t_byte_tab INV_SBOX = gen_inv_sbox();

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int n = 0; n < 16; n++) begin
            t[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [1:0] from;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                from = inv ? 2'(c + 4 - r) : 2'(c + r);
                t[127-8*(c*4+r) -: 8] = s[127-8*(int'(from)*4+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [3:0][7:0] m;
        logic [7:0] acc;
        m = inv ? {8'h0e, 8'h0b, 8'h0d, 8'h09} : {8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf_mul(m[3-k], s[127-8*(c*4+((r+k)%4)) -: 8]);
                end
                t[127-8*(c*4+r) -: 8] = acc;
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/aes_block_encrypt_decrypt_core.sv @@
// Every item passes through the whole stage chain r_st[0] to r_st[NR_MAX] for every key size.
// Throughput: one item per cycle while o_stall is low; each round has its own pipeline stage.
// After reset and after each write to a key or key-size register the key schedule is
// built one 32-bit word per cycle, up to 4 * MAX_ROUND_KEYS words, and no item is taken then.
// Reset is synchronous and active low; it clears the key registers and valid bits.
`default_nettype none

module aes_block_encrypt_decrypt_core #(
    parameter int MAX_ROUND_KEYS = aes_pkg::MAX_ROUND_KEYS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_action,
    input  wire  [63:0] i_block_high,
    input  wire  [63:0] i_block_low,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);

    localparam int NR_MAX = MAX_ROUND_KEYS - 1;
    localparam int RK_W = $clog2(MAX_ROUND_KEYS);
    localparam int WI_W = RK_W + 2;

    logic [63:0] r_key [4];
    logic [1:0]  r_key_size;
    logic        r_busy;
    logic [WI_W-1:0] r_wi;
    logic [2:0]  r_jm;
    logic [7:0]  r_rcon;
    logic [31:0] r_win [8];
    logic [127:0] r_enc_rk [MAX_ROUND_KEYS];
    logic [127:0] r_dec_rk [MAX_ROUND_KEYS];

    logic [1:0]  ks;
    logic [3:0]  nk;
    logic [RK_W-1:0] nr;
    logic [255:0] key_all;
    logic [31:0] n_word;
    logic [31:0] mix_word;
    logic [RK_W-1:0] wr_round;
    logic [RK_W-1:0] dec_round;
    logic        exp_last;
    logic        cfg_hit;

    always_comb begin
        ks = (r_key_size == aes_pkg::KEY_SIZE_128) ? aes_pkg::KEY_SIZE_128 :
             (r_key_size == aes_pkg::KEY_SIZE_192) ? aes_pkg::KEY_SIZE_192 :
             aes_pkg::KEY_SIZE_256;
        nk = 4'd4 + {1'b0, ks, 1'b0};
        if (32'(nk) + 32'd6 > 32'(NR_MAX)) begin
            nr = RK_W'(NR_MAX);
        end else begin
            nr = RK_W'(nk + 4'd6);
        end
        key_all = {r_key[0], r_key[1], r_key[2], r_key[3]};
        mix_word = r_win[0];
        if (r_jm == 3'd0) begin
            mix_word = aes_pkg::sub_word({r_win[0][23:0], r_win[0][31:24]})
                ^ {r_rcon, 24'h000000};
        end else if (nk == 4'd8 && r_jm == 3'd4) begin
            mix_word = aes_pkg::sub_word(r_win[0]);
        end
        if (32'(r_wi) < 32'(nk)) begin
            n_word = key_all[255 - 32 * int'(r_wi[2:0]) -: 32];
        end else begin
            n_word = r_win[3'(nk - 4'd1)] ^ mix_word;
        end
        wr_round = r_wi[WI_W-1:2];
        dec_round = nr - wr_round;
        exp_last = (r_wi == {nr, 2'b11});
        cfg_hit = i_cfg_we && (i_cfg_index inside {aes_pkg::REG_KEY_0, aes_pkg::REG_KEY_1,
            aes_pkg::REG_KEY_2, aes_pkg::REG_KEY_3, aes_pkg::REG_KEY_SIZE});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
            r_key_size <= aes_pkg::KEY_SIZE_128;
            r_busy <= 1'b1;
            r_wi <= '0;
            r_jm <= '0;
            r_rcon <= 8'h01;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                aes_pkg::REG_KEY_0: r_key[0] <= i_cfg_data;
                aes_pkg::REG_KEY_1: r_key[1] <= i_cfg_data;
                aes_pkg::REG_KEY_2: r_key[2] <= i_cfg_data;
                aes_pkg::REG_KEY_3: r_key[3] <= i_cfg_data;
                aes_pkg::REG_KEY_SIZE: r_key_size <= i_cfg_data[1:0];
                default: r_key_size <= r_key_size;
            endcase
            r_busy <= 1'b1;
            r_wi <= '0;
            r_jm <= '0;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_busy <= !exp_last;
            r_wi <= r_wi + WI_W'(1);
            r_jm <= (r_jm == 3'(nk - 4'd1)) ? 3'd0 : r_jm + 3'd1;
            if (r_jm == 3'd0 && 32'(r_wi) >= 32'(nk)) begin
                r_rcon <= aes_pkg::gf_mul(8'h02, r_rcon);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !cfg_hit) begin
            r_win[0] <= n_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_enc_rk[wr_round][127 - 32 * int'(r_wi[1:0]) -: 32] <= n_word;
            r_dec_rk[dec_round][127 - 32 * int'(r_wi[1:0]) -: 32] <= n_word;
        end
    end

    logic         r_v   [NR_MAX+1];
    logic         r_dec [NR_MAX+1];
    logic [127:0] r_st  [NR_MAX+1];
    logic [127:0] n_st  [NR_MAX+1];
    logic         en;
    logic [127:0] x;
    logic [127:0] rk;

    assign en = !r_v[NR_MAX] || !i_stall;
    assign o_stall = !en || r_busy;

    always_comb begin
        n_st[0] = {i_block_high, i_block_low}
            ^ ((i_action == aes_pkg::ACTION_DECRYPT) ? r_dec_rk[0] : r_enc_rk[0]);
        x = '0;
        rk = '0;
        for (int k = 1; k <= NR_MAX; k++) begin
            rk = r_dec[k-1] ? r_dec_rk[k] : r_enc_rk[k];
            if (r_dec[k-1]) begin
                x = aes_pkg::sub_bytes(aes_pkg::shift_rows(r_st[k-1], 1'b1), 1'b1) ^ rk;
                if (k < int'(nr)) begin
                    x = aes_pkg::mix_columns(x, 1'b1);
                end
            end else begin
                x = aes_pkg::shift_rows(aes_pkg::sub_bytes(r_st[k-1], 1'b0), 1'b0);
                if (k < int'(nr)) begin
                    x = aes_pkg::mix_columns(x, 1'b0);
                end
                x = x ^ rk;
            end
            n_st[k] = (k > int'(nr)) ? r_st[k-1] : x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NR_MAX; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid && !r_busy;
            for (int k = 1; k <= NR_MAX; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dec[0] <= i_action;
            r_st[0] <= n_st[0];
            for (int k = 1; k <= NR_MAX; k++) begin
                r_dec[k] <= r_dec[k-1];
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_v[NR_MAX];
    assign o_result_high = r_st[NR_MAX][127:64];
    assign o_result_low = r_st[NR_MAX][63:0];

    a_no_item_while_expanding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall)
        else $error("item accepted during key expansion");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NR_MAX] && i_stall) |=> (r_v[NR_MAX] && $stable(r_st[NR_MAX])))
        else $error("stalled result lost or changed");

    a_expansion_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_wi <= {nr, 2'b11}))
        else $error("key expansion ran past the schedule");

endmodule

`default_nettype wire

@@ verif/aes_checker.sv @@
`default_nettype none

module aes_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_valid,
    input  wire         i_stall_in,
    input  wire         i_action,
    input  wire  [63:0] i_block_high,
    input  wire  [63:0] i_block_low,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire  [63:0] i_result_high,
    input  wire  [63:0] i_result_low,
    output int          o_errors,
    output int          o_pending
);

    localparam int SLOTS = 4 * aes_pkg::MAX_ROUND_KEYS;

    logic [63:0] key_regs [4];
    logic [1:0] key_len;
    logic [31:0] sched [SLOTS];
    int rounds;
    int err_count = 0;
    logic [127:0] expected_blocks [$];
    logic [7:0] sbox_tab [256];
    logic [7:0] inv_tab [256];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] y;
        acc = 0;
        y = b;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) begin
                acc ^= y;
            end
            y = {y[6:0], 1'b0} ^ (y[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] p;
        p = 8'h01;
        for (int i = 0; i < 254; i++) begin
            p = gmul(p, a);
        end
        return p;
    endfunction

    function automatic logic [31:0] sub32(input logic [31:0] w);
        return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
    endfunction

    task automatic build_schedule();
        int nk;
        int total;
        int ks;
        logic [7:0] rc;
        logic [31:0] t;
        ks = (key_len == 2'd3) ? 2 : int'(key_len);
        nk = 4 + 2 * ks;
        rounds = nk + 6;
        if (rounds > aes_pkg::MAX_ROUND_KEYS - 1) begin
            rounds = aes_pkg::MAX_ROUND_KEYS - 1;
        end
        total = 4 * (rounds + 1);
        rc = 8'h01;
        for (int i = 0; i < SLOTS; i++) begin
            sched[i] = 0;
        end
        for (int i = 0; i < total; i++) begin
            if (i < nk) begin
                sched[i] = (i % 2 == 0) ? key_regs[i / 2][63:32] : key_regs[i / 2][31:0];
            end else begin
                t = sched[i - 1];
                if (i % nk == 0) begin
                    t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    rc = gmul(8'h02, rc);
                end else if (nk > 6 && i % nk == 4) begin
                    t = sub32(t);
                end
                sched[i] = sched[i - nk] ^ t;
            end
        end
    endtask

    function automatic logic [127:0] add_key(input logic [127:0] s, input int r);
        return s ^ {sched[(4*r) % SLOTS], sched[(4*r+1) % SLOTS],
                    sched[(4*r+2) % SLOTS], sched[(4*r+3) % SLOTS]};
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int n = 0; n < 16; n++) begin
            t[127-8*n -: 8] = inv ? inv_tab[s[127-8*n -: 8]] : sbox_tab[s[127-8*n -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
                t[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0] m [4];
        logic [7:0] acc;
        if (inv) begin
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        end else begin
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    acc ^= gmul(m[k], s[127-8*(c*4+(r+k)%4) -: 8]);
                end
                t[127-8*(c*4+r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] b);
        logic [127:0] s;
        if (dec == aes_pkg::ACTION_ENCRYPT) begin
            s = add_key(b, 0);
            for (int i = 1; i < rounds; i++) begin
                s = add_key(mix(rotate_rows(subst(s, 1'b0), 1'b0), 1'b0), i);
            end
            s = add_key(rotate_rows(subst(s, 1'b0), 1'b0), rounds);
        end else begin
            s = add_key(b, rounds);
            for (int i = rounds - 1; i > 0; i--) begin
                s = mix(add_key(subst(rotate_rows(s, 1'b1), 1'b1), i), 1'b1);
            end
            s = add_key(subst(rotate_rows(s, 1'b1), 1'b1), 0);
        end
        return s;
    endfunction

    initial begin
        logic [7:0] b;
        for (int a = 0; a < 256; a++) begin
            b = ginv(8'(a));
            sbox_tab[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
        for (int a = 0; a < 256; a++) begin
            inv_tab[sbox_tab[a]] = 8'(a);
        end
    end

    assign o_errors = err_count;
    assign o_pending = expected_blocks.size();

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                key_regs[i] = 0;
            end
            key_len = aes_pkg::KEY_SIZE_128;
            build_schedule();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected result %h %h", $time,
                             i_result_high, i_result_low);
                    err_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_result_high !== want[127:64]) begin
                        $display("%0t: result_high expected %h actual %h", $time,
                                 want[127:64], i_result_high);
                        err_count++;
                    end
                    if (i_result_low !== want[63:0]) begin
                        $display("%0t: result_low expected %h actual %h", $time,
                                 want[63:0], i_result_low);
                        err_count++;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                expected_blocks.push_back(cipher_block(i_action, {i_block_high, i_block_low}));
            end
            if (i_cfg_we && i_cfg_index <= aes_pkg::REG_KEY_SIZE) begin
                if (i_cfg_index == aes_pkg::REG_KEY_SIZE) begin
                    key_len = i_cfg_data[1:0];
                end else begin
                    key_regs[i_cfg_index] = i_cfg_data;
                end
                build_schedule();
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = 0;
    logic [63:0] i_cfg_data = 0;
    logic i_valid = 0;
    logic i_action = 0;
    logic [63:0] i_block_high = 0;
    logic [63:0] i_block_low = 0;
    logic i_stall = 0;
    logic o_stall;
    logic o_valid;
    logic [63:0] o_result_high;
    logic [63:0] o_result_low;
    int errors;
    int pending;
    int cycles = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_cycles = 0;
    int hold_req = 0;
    int hold_ack = 0;

    aes_block_encrypt_decrypt_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_action(i_action),
        .i_block_high(i_block_high), .i_block_low(i_block_low),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_high(o_result_high), .o_result_low(o_result_low)
    );

    aes_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_action(i_action),
        .i_block_high(i_block_high), .i_block_low(i_block_low),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_result_high(o_result_high), .i_result_low(o_result_low),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cycles <= 80;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h1 << $urandom_range(63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_block_high <= hi;
        i_block_low <= lo;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (aes_pkg::MAX_ROUND_KEYS + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] sz, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        drain();
        write_reg(aes_pkg::REG_KEY_0, k0);
        write_reg(aes_pkg::REG_KEY_1, k1);
        write_reg(aes_pkg::REG_KEY_2, k2);
        write_reg(aes_pkg::REG_KEY_3, k3);
        write_reg(aes_pkg::REG_KEY_SIZE, {62'b0, sz});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [1:0] sz;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_block(aes_pkg::ACTION_ENCRYPT, 64'h0, 64'h0);
        send_block(aes_pkg::ACTION_DECRYPT, 64'h0, 64'h0);
        load_key(aes_pkg::KEY_SIZE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(aes_pkg::ACTION_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(aes_pkg::ACTION_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(aes_pkg::ACTION_ENCRYPT, '1, '1);
        send_block(aes_pkg::ACTION_DECRYPT, '1, '1);
        load_key(aes_pkg::KEY_SIZE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        send_block(aes_pkg::ACTION_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(aes_pkg::ACTION_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        load_key(aes_pkg::KEY_SIZE_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(aes_pkg::ACTION_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(aes_pkg::ACTION_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        load_key(2'd3, '1, '1, '1, '1);
        send_block(aes_pkg::ACTION_ENCRYPT, 64'h0, '1);
        send_block(aes_pkg::ACTION_DECRYPT, '1, 64'h0);
        drain();
        write_reg(3'd5, '1);
        write_reg(3'd7, 64'h5a5a);
        i_cfg_we <= 1'b0;
        send_block(aes_pkg::ACTION_ENCRYPT, 64'h8000000000000000, 64'h1);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 61 : 0;
            receiver_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 17 : 0;
            for (int set = 0; set < 6; set++) begin
                sz = 2'($urandom_range(3));
                load_key(sz, rand64(), rand64(), rand64(), rand64());
                if (set == 2) begin
                    hold_req++;
                end
                for (int n = 0; n < 100; n++) begin
                    if (n == 50) begin
                        drain();
                    end
                    send_block(1'($urandom_range(1)), rand64(), rand64());
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
